[hdl/tplc_pkg.sv]
`timescale 1ns / 1ps

package tplc_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int KEY_BITS    = 32;
	localparam int COUNT_BITS  = 16;
	localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
	localparam int TOTAL_BITS  = $clog2(MAX_ENTRIES + 1);

	localparam int THRESH_BITS    = 16;
	localparam int LIMIT_BITS     = 4;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT     = 1'd1;

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd5;
	localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 4'd7;

	typedef enum logic {
		OP_ACCESS = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_TRIM
	} state_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_BITS-1:0] access_key;
	} in_t;

	typedef struct packed {
		logic                  hit;
		logic [COUNT_BITS-1:0] hit_count;
		logic                  promoted;
		logic                  evicted;
		logic [KEY_BITS-1:0]   evicted_key;
		logic [TOTAL_BITS-1:0] occupancy;
	} out_t;

	typedef struct packed {
		logic lookup;
		logic finish;
	} cmd_t;

endpackage

[hdl/tplc_ctrl.sv]
`timescale 1ns / 1ps

module tplc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output tplc_pkg::cmd_t cmd
);
	import tplc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.lookup = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.lookup = in_valid;
			end
			ST_TRIM: begin
				cmd.finish = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/tplc_datapath.sv]
`timescale 1ns / 1ps

module tplc_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tplc_pkg::cmd_t                          cmd,
	input  tplc_pkg::in_t                           in_data,
	input  logic                                    cfg_we,
	input  logic [tplc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [tplc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	output tplc_pkg::out_t                          out_data
);
	import tplc_pkg::*;

	logic [KEY_BITS-1:0]    keys_q   [MAX_ENTRIES];
	logic [COUNT_BITS-1:0]  counts_q [MAX_ENTRIES];
	logic [SLOT_BITS-1:0]   order_q  [MAX_ENTRIES];
	logic [TOTAL_BITS-1:0]  total_q;
	logic [THRESH_BITS-1:0] threshold_q;
	logic [LIMIT_BITS-1:0]  limit_q;

	op_t                   op_s1;
	logic                  hit_s1;
	logic [COUNT_BITS-1:0] count_s1;
	logic                  promoted_s1;
	logic                  evicted_s1;
	logic [KEY_BITS-1:0]   evkey_s1;
	out_t                  res_q;

	logic [MAX_ENTRIES-1:0] slot_hit;
	logic [MAX_ENTRIES-1:0] pos_match;
	logic                   hit_any;
	logic [SLOT_BITS-1:0]   hit_pos;
	logic [SLOT_BITS-1:0]   hit_slot;
	logic [COUNT_BITS-1:0]  cnt_inc;
	logic                   promote;
	logic                   full;
	logic [SLOT_BITS-1:0]   ins_pos;
	logic [SLOT_BITS-1:0]   ins_slot;
	logic [SLOT_BITS-1:0]   move_pos;
	logic                   rotate;
	logic [SLOT_BITS-1:0]   new_order [MAX_ENTRIES];
	logic [TOTAL_BITS-1:0]  lim;
	logic                   trim;
	logic [SLOT_BITS-1:0]   rd_pos;
	logic [KEY_BITS-1:0]    rd_key;
	logic                   is_access;

	assign is_access = (in_data.op == OP_ACCESS);

	// hit search: compare all slots, then map through the order
	always_comb begin
		for (int s = 0; s < MAX_ENTRIES; s++) begin
			slot_hit[s] = (keys_q[s] == in_data.access_key);
		end
		for (int p = 0; p < MAX_ENTRIES; p++) begin
			pos_match[p] = (TOTAL_BITS'(p) < total_q) && slot_hit[order_q[p]];
		end
		hit_any = |pos_match;
		hit_pos = '0;
		for (int p = MAX_ENTRIES - 1; p >= 0; p--) begin
			if (pos_match[p]) begin
				hit_pos = SLOT_BITS'(p);
			end
		end
	end

	assign hit_slot = order_q[hit_pos];
	assign cnt_inc  = (&counts_q[hit_slot]) ? counts_q[hit_slot]
	                                        : counts_q[hit_slot] + COUNT_BITS'(1);
	assign promote  = hit_any && (32'(cnt_inc) > 32'(threshold_q)) && (hit_pos != '0);
	assign full     = (total_q == TOTAL_BITS'(MAX_ENTRIES));
	assign ins_pos  = full ? SLOT_BITS'(MAX_ENTRIES - 1) : total_q[SLOT_BITS-1:0];
	assign ins_slot = order_q[ins_pos];
	assign move_pos = hit_any ? hit_pos : ins_pos;
	assign rotate   = is_access && (hit_any ? promote : 1'b1);

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (i == 0) begin
				new_order[i] = order_q[move_pos];
			end else if (SLOT_BITS'(i) <= move_pos) begin
				new_order[i] = order_q[i - 1];
			end else begin
				new_order[i] = order_q[i];
			end
		end
	end

	// trim to the limit
	assign lim  = (32'(limit_q) > MAX_ENTRIES) ? TOTAL_BITS'(MAX_ENTRIES)
	                                          : TOTAL_BITS'(limit_q);
	assign trim = (op_s1 == OP_ACCESS) && (total_q > lim);

	// single key read port: tail on lookup, limit position (first trimmed entry) on finish
	assign rd_pos = cmd.lookup ? SLOT_BITS'(MAX_ENTRIES - 1) : lim[SLOT_BITS-1:0];
	assign rd_key = keys_q[order_q[rd_pos]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			threshold_q <= THRESH_RESET;
			limit_q     <= LIMIT_RESET;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				order_q[i] <= SLOT_BITS'(i);
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_THRESHOLD: threshold_q <= THRESH_BITS'(cfg_data);
					CFG_LIMIT:     limit_q     <= LIMIT_BITS'(cfg_data);
					default: ;
				endcase
			end
			if (cmd.lookup) begin
				if (!is_access) begin
					total_q <= '0;
				end else if (!hit_any && !full) begin
					total_q <= total_q + TOTAL_BITS'(1);
				end
				if (rotate) begin
					order_q <= new_order;
				end
			end else if (cmd.finish && trim) begin
				total_q <= lim;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			op_s1 <= in_data.op;
			if (!is_access) begin
				hit_s1      <= 1'b0;
				count_s1    <= '0;
				promoted_s1 <= 1'b0;
				evicted_s1  <= 1'b0;
				evkey_s1    <= '0;
			end else if (hit_any) begin
				counts_q[hit_slot] <= cnt_inc;
				hit_s1      <= 1'b1;
				count_s1    <= cnt_inc;
				promoted_s1 <= promote;
				evicted_s1  <= 1'b0;
				evkey_s1    <= '0;
			end else begin
				keys_q[ins_slot]   <= in_data.access_key;
				counts_q[ins_slot] <= COUNT_BITS'(1);
				hit_s1      <= 1'b0;
				count_s1    <= COUNT_BITS'(1);
				promoted_s1 <= 1'b0;
				evicted_s1  <= full;
				evkey_s1    <= full ? rd_key : '0;
			end
		end
		if (cmd.finish) begin
			res_q.hit         <= hit_s1;
			res_q.hit_count   <= count_s1;
			res_q.promoted    <= promoted_s1;
			res_q.evicted     <= evicted_s1 || trim;
			res_q.evicted_key <= trim ? rd_key : evkey_s1;
			res_q.occupancy   <= trim ? lim : total_q;
		end
	end

	assign out_data = res_q;

endmodule

[hdl/threshold_promote_lru_cache.sv]
`timescale 1ns / 1ps
// Result registered after the input transaction passes lookup/update, then trim.
// No new transaction is taken until trim is done; the slot arrays take the update in the
//   lookup step and the limit trim with its evicted key read in the trim step.
// A stalled output holds the block in the trim cycle until the result is taken.
// Reset: occupancy 0, slot order identity, threshold 5, entry limit 7, no result pending.
module threshold_promote_lru_cache (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tplc_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tplc_pkg::out_t                      out_data,
	input  logic                                cfg_we,
	input  logic [tplc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tplc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import tplc_pkg::*;

	cmd_t cmd;

	tplc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tplc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

[hdl/tplc_checker.sv]
`timescale 1ns / 1ps

module tplc_sva (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input tplc_pkg::out_t out_data
);
	import tplc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transaction accepted while busy");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.occupancy) <= MAX_ENTRIES)
		else $error("occupancy above capacity");

	a_promote_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> !out_data.promoted)
		else $error("promotion without hit");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.evicted |-> out_data.evicted_key == '0)
		else $error("evicted key without eviction");

endmodule

bind threshold_promote_lru_cache tplc_sva u_tplc_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[verif/tplc_checker.sv]
`timescale 1ns / 1ps

module tplc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  tplc_pkg::in_t                       in_data,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  tplc_pkg::out_t                      out_data,
	input  logic                                cfg_we,
	input  logic [tplc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tplc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int unsigned                         fail_count,
	output int unsigned                         pending
);
	import tplc_pkg::*;

	logic [THRESH_BITS-1:0] promote_thresh;
	logic [LIMIT_BITS-1:0]  keep_limit;
	logic [KEY_BITS-1:0]    tag_store [MAX_ENTRIES];
	logic [COUNT_BITS-1:0]  hit_store [MAX_ENTRIES];
	int                     slot_order [MAX_ENTRIES];
	int                     live_total;

	out_t lookup_results_q [$];
	out_t predicted;
	out_t oldest;

	function automatic void move_front(int pos);
		int s;
		s = slot_order[pos];
		for (int i = pos; i > 0; i--)
			slot_order[i] = slot_order[i-1];
		slot_order[0] = s;
	endfunction

	function automatic out_t predict_lookup(in_t t);
		out_t r;
		int   pos;
		int   s;
		int   lim;
		r = '0;
		if (t.op == OP_CLEAR) begin
			live_total = 0;
		end else begin
			pos = live_total;
			for (int i = 0; i < live_total; i++) begin
				if (pos == live_total && tag_store[slot_order[i]] == t.access_key)
					pos = i;
			end
			if (pos < live_total) begin
				s = slot_order[pos];
				r.hit = 1'b1;
				if (hit_store[s] != '1)
					hit_store[s] = hit_store[s] + 1'b1;
				r.hit_count = hit_store[s];
				if (hit_store[s] > promote_thresh && pos > 0) begin
					move_front(pos);
					r.promoted = 1'b1;
				end
			end else begin
				// full store: tail goes first so its slot can be reused
				if (live_total >= MAX_ENTRIES) begin
					live_total = MAX_ENTRIES - 1;
					r.evicted_key = tag_store[slot_order[live_total]];
					r.evicted = 1'b1;
				end
				s = slot_order[live_total];
				tag_store[s] = t.access_key;
				hit_store[s] = COUNT_BITS'(1);
				move_front(live_total);
				live_total++;
				r.hit_count = COUNT_BITS'(1);
			end
			lim = (keep_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(keep_limit);
			while (live_total > lim) begin
				live_total--;
				r.evicted_key = tag_store[slot_order[live_total]];
				r.evicted = 1'b1;
			end
		end
		r.occupancy = TOTAL_BITS'(live_total);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			promote_thresh = THRESH_RESET;
			keep_limit = LIMIT_RESET;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				tag_store[i] = '0;
				hit_store[i] = '0;
				slot_order[i] = i;
			end
			live_total = 0;
			lookup_results_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_THRESHOLD)
					promote_thresh = cfg_data[THRESH_BITS-1:0];
				else if (cfg_index == CFG_LIMIT)
					keep_limit = cfg_data[LIMIT_BITS-1:0];
			end
			if (in_valid && in_ready) begin
				predicted = predict_lookup(in_data);
				lookup_results_q.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (lookup_results_q.size() == 0) begin
					$error("result transaction with no lookup pending");
					fail_count++;
				end else begin
					oldest = lookup_results_q.pop_front();
					check_field("hit", 64'(oldest.hit), 64'(out_data.hit));
					check_field("hit_count", 64'(oldest.hit_count),
					            64'(out_data.hit_count));
					check_field("promoted", 64'(oldest.promoted),
					            64'(out_data.promoted));
					check_field("evicted", 64'(oldest.evicted), 64'(out_data.evicted));
					check_field("evicted_key", 64'(oldest.evicted_key),
					            64'(out_data.evicted_key));
					check_field("occupancy", 64'(oldest.occupancy),
					            64'(out_data.occupancy));
				end
			end
			pending = lookup_results_q.size();
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import tplc_pkg::*;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	in_t                       in_data;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	out_t                      out_data;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int unsigned               fail_count;
	int unsigned               pending;

	bit calm;
	int burst_left;
	int ready_run = 0;
	bit ready_hold;

	always #4 clk = ~clk;

	threshold_promote_lru_cache u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tplc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else begin
			if (ready_run == 0) begin
				ready_hold = ($urandom_range(0, 2) != 0);
				ready_run = ready_hold ? $urandom_range(1, 30) : $urandom_range(1, 6);
			end
			ready_run--;
			out_ready <= ready_hold;
		end
	end

	task automatic issue(input op_t op, input logic [KEY_BITS-1:0] key);
		in_t t;
		int  gap;
		t.op = op;
		t.access_key = key;
		in_valid <= 1'b1;
		in_data <= t;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = calm ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [KEY_BITS-1:0]      key_pool [16];
		logic [CFG_DATA_BITS-1:0] cfg_word;
		logic [THRESH_BITS-1:0]   thr;
		logic [LIMIT_BITS-1:0]    lim;
		int                       pool_n;
		int                       roll;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_data = '0;
		calm = 1'b0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset config: threshold 5, limit 7
		issue(OP_ACCESS, 32'h0000_0000);
		issue(OP_ACCESS, 32'hFFFF_FFFF);
		issue(OP_ACCESS, 32'h0000_0000);
		issue(OP_ACCESS, 32'h0000_0000);
		for (int i = 1; i <= 6; i++)
			issue(OP_ACCESS, 32'h0101_0101 * i);
		issue(OP_CLEAR, 32'hDEAD_BEEF);
		drain();

		// promote on any hit; limit 9 acts as 8, upper data bits ignored
		write_cfg(CFG_THRESHOLD, 16'h0000);
		write_cfg(CFG_LIMIT, 16'hFFF9);
		issue(OP_ACCESS, 32'hA5A5_A5A5);
		issue(OP_ACCESS, 32'h5A5A_5A5A);
		issue(OP_ACCESS, 32'hA5A5_A5A5);
		issue(OP_ACCESS, 32'hA5A5_A5A5);
		for (int i = 1; i <= 6; i++)
			issue(OP_ACCESS, 32'h8000_0000 | i);
		issue(OP_ACCESS, 32'h7FFF_FFFF);
		drain();
		write_cfg(CFG_LIMIT, 16'd2);
		issue(OP_ACCESS, 32'h8000_0001);
		drain();
		write_cfg(CFG_LIMIT, 16'd0);
		issue(OP_ACCESS, 32'h1234_5678);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			unique case (ph)
				0: begin thr = 16'd0;   lim = 4'd8;  end
				1: begin thr = 16'd1;   lim = 4'd3;  end
				2: begin thr = 16'hFFFF; lim = 4'd15; end
				3: begin thr = 16'd2;   lim = 4'd1;  end
				4: begin thr = THRESH_BITS'($urandom); lim = 4'd5; end
				default: begin
					thr = THRESH_BITS'($urandom_range(0, 8));
					lim = LIMIT_BITS'($urandom_range(0, 15));
				end
			endcase
			cfg_word = CFG_DATA_BITS'($urandom);
			cfg_word[LIMIT_BITS-1:0] = lim;
			write_cfg(CFG_THRESHOLD, thr);
			write_cfg(CFG_LIMIT, cfg_word);
			calm = (ph == 2);
			pool_n = $urandom_range(2, 12);
			for (int i = 0; i < pool_n; i++)
				key_pool[i] = $urandom;
			for (int n = 0; n < 140; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					issue(OP_CLEAR, $urandom);
				else if (roll < 13)
					issue(OP_ACCESS, $urandom);
				else
					issue(OP_ACCESS, key_pool[$urandom_range(0, pool_n - 1)]);
			end
			drain();
		end

		// high threshold: hits keep counting with no promotion
		calm = 1'b1;
		write_cfg(CFG_THRESHOLD, 16'hFFFE);
		write_cfg(CFG_LIMIT, 16'd8);
		issue(OP_ACCESS, 32'h0BAD_F00D);
		issue(OP_ACCESS, 32'hC0FF_EE00);
		repeat (20) issue(OP_ACCESS, 32'h0BAD_F00D);
		drain();
		write_cfg(CFG_THRESHOLD, 16'hFFFF);
		issue(OP_ACCESS, 32'h0000_0001);
		issue(OP_ACCESS, 32'h0BAD_F00D);
		issue(OP_ACCESS, 32'h0BAD_F00D);
		drain();
		calm = 1'b0;

		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("threshold_promote_lru_cache verification clean");
		else
			$display("threshold_promote_lru_cache verification failed");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("threshold_promote_lru_cache verification failed");
		$finish;
	end

endmodule

[threshold_promote_lru_cache.f]
hdl/tplc_pkg.sv
hdl/tplc_ctrl.sv
hdl/tplc_datapath.sv
hdl/threshold_promote_lru_cache.sv
hdl/tplc_checker.sv
verif/tplc_checker.sv
verif/tb_top.sv
